[hdl/ntte_pkg.sv]
// Shared types, phase and status codes for the notification title extractor.
package ntte_pkg;

	localparam int unsigned POS_W = 16;

	// Parse phases
	localparam logic [2:0] PH_CMD   = 3'd0;
	localparam logic [2:0] PH_UID   = 3'd1;
	localparam logic [2:0] PH_ID    = 3'd2;
	localparam logic [2:0] PH_LO    = 3'd3;
	localparam logic [2:0] PH_HI    = 3'd4;
	localparam logic [2:0] PH_SKIP  = 3'd5;
	localparam logic [2:0] PH_TITLE = 3'd6;
	localparam logic [2:0] PH_DONE  = 3'd7;

	// Status codes
	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BADCMD    = 3'd2;
	localparam logic [2:0] ST_MALFORMED = 3'd3;
	localparam logic [2:0] ST_ABSENT    = 3'd4;

	// Result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_CHAR   = 1'b1;

	// Register indexes
	localparam logic [1:0] REG_EXPECTED_COMMAND = 2'd0;
	localparam logic [1:0] REG_TITLE_ATTRIBUTE  = 2'd1;
	localparam logic [1:0] REG_TITLE_LIMIT      = 2'd2;

	localparam logic [POS_W-1:0] MIN_PACKET   = 16'd5;
	localparam logic [POS_W:0]   HEADER_BYTES = 17'd3;
	localparam logic [POS_W-1:0] UID_BYTES    = 16'd4;

	typedef struct packed {
		logic [7:0]       expected_command;
		logic [7:0]       title_attribute;
		logic [POS_W-1:0] title_limit;
	} cfg_t;

	typedef struct packed {
		logic             result_kind;
		logic [2:0]       status_code;
		logic [POS_W-1:0] title_length;
		logic [7:0]       title_char;
		logic             title_end;
	} res_t;

endpackage

[hdl/ntte_parser.sv]
// Packet parse state and the per-byte step logic of the title extractor.
module ntte_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ntte_pkg::cfg_t              cfg,
	input  logic                        step,
	input  logic [7:0]                  data_byte,
	input  logic [ntte_pkg::POS_W-1:0]  packet_length,
	output logic                        res_valid,
	output ntte_pkg::res_t              res
);

	logic [ntte_pkg::POS_W-1:0] byte_position_q, latched_length_q;
	logic [ntte_pkg::POS_W-1:0] record_length_q, bytes_left_q;
	logic [7:0]                 record_id_q;
	logic [2:0]                 parse_phase_q;

	logic [ntte_pkg::POS_W-1:0] len_eff, remaining, rec_len_full, clip, left_dec;
	logic [ntte_pkg::POS_W-1:0] pos_d, len_d, rec_len_d, left_d;
	logic [ntte_pkg::POS_W:0]   pos_inc;
	logic [7:0]                 rec_id_d;
	logic [2:0]                 phase_eff, phase_d, phase_step;
	logic                       last, hit;
	ntte_pkg::res_t             res_d;

	always_comb begin
		len_eff      = (byte_position_q == '0) ? packet_length : latched_length_q;
		phase_eff    = (byte_position_q == '0) ? ntte_pkg::PH_CMD : parse_phase_q;
		pos_inc      = {1'b0, byte_position_q} + 17'd1;
		last         = (pos_inc >= {1'b0, len_eff});
		remaining    = last ? '0 : (len_eff - pos_inc[ntte_pkg::POS_W-1:0]);
		rec_len_full = {data_byte, record_length_q[7:0]};
		clip         = (rec_len_full < cfg.title_limit) ? rec_len_full : cfg.title_limit;
		left_dec     = bytes_left_q - 16'd1;

		hit        = 1'b0;
		res_d      = '0;
		phase_step = phase_eff;
		rec_id_d   = record_id_q;
		rec_len_d  = record_length_q;
		left_d     = bytes_left_q;

		unique case (phase_eff)
			ntte_pkg::PH_CMD: begin
				if (len_eff < ntte_pkg::MIN_PACKET) begin
					hit = 1'b1;
					res_d.status_code = ntte_pkg::ST_SHORT;
					phase_step = ntte_pkg::PH_DONE;
				end else if (data_byte != cfg.expected_command) begin
					hit = 1'b1;
					res_d.status_code = ntte_pkg::ST_BADCMD;
					phase_step = ntte_pkg::PH_DONE;
				end else begin
					phase_step = ntte_pkg::PH_UID;
					left_d = ntte_pkg::UID_BYTES;
				end
			end
			ntte_pkg::PH_UID, ntte_pkg::PH_SKIP: begin
				left_d = left_dec;
				if (left_dec == '0) phase_step = ntte_pkg::PH_ID;
			end
			ntte_pkg::PH_ID: begin
				// ignore a tail too short to hold a record header
				if (({1'b0, remaining} + 17'd1) >= ntte_pkg::HEADER_BYTES) begin
					rec_id_d = data_byte;
					phase_step = ntte_pkg::PH_LO;
				end
			end
			ntte_pkg::PH_LO: begin
				rec_len_d = {8'd0, data_byte};
				phase_step = ntte_pkg::PH_HI;
			end
			ntte_pkg::PH_HI: begin
				rec_len_d = rec_len_full;
				if (rec_len_full > remaining) begin
					hit = 1'b1;
					res_d.status_code = ntte_pkg::ST_MALFORMED;
					phase_step = ntte_pkg::PH_DONE;
				end else if (record_id_q == cfg.title_attribute) begin
					hit = 1'b1;
					res_d.status_code = ntte_pkg::ST_FOUND;
					res_d.title_length = clip;
					if (clip == '0) begin
						phase_step = ntte_pkg::PH_DONE;
					end else begin
						phase_step = ntte_pkg::PH_TITLE;
						left_d = clip;
					end
				end else if (rec_len_full == '0) begin
					phase_step = ntte_pkg::PH_ID;
				end else begin
					phase_step = ntte_pkg::PH_SKIP;
					left_d = rec_len_full;
				end
			end
			ntte_pkg::PH_TITLE: begin
				left_d = left_dec;
				hit = 1'b1;
				res_d.result_kind = ntte_pkg::KIND_CHAR;
				res_d.title_char = data_byte;
				res_d.title_end = (left_dec == '0);
				if (left_dec == '0) phase_step = ntte_pkg::PH_DONE;
			end
			ntte_pkg::PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (last) begin
			if (!hit && phase_step != ntte_pkg::PH_DONE) begin
				hit = 1'b1;
				res_d = '0;
				res_d.status_code = ntte_pkg::ST_ABSENT;
			end
			pos_d   = '0;
			phase_d = ntte_pkg::PH_CMD;
		end else begin
			pos_d   = pos_inc[ntte_pkg::POS_W-1:0];
			phase_d = phase_step;
		end
		len_d = len_eff;
	end

	assign res_valid = step && hit;
	assign res       = res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q  <= '0;
			latched_length_q <= '0;
			parse_phase_q    <= ntte_pkg::PH_CMD;
			record_id_q      <= '0;
			record_length_q  <= '0;
			bytes_left_q     <= '0;
		end else if (step) begin
			byte_position_q  <= pos_d;
			latched_length_q <= len_d;
			parse_phase_q    <= phase_d;
			record_id_q      <= rec_id_d;
			record_length_q  <= rec_len_d;
			bytes_left_q     <= left_d;
		end
	end

	a_title_left: assert property (@(posedge clk) disable iff (!arst_n)
		parse_phase_q == ntte_pkg::PH_TITLE |-> bytes_left_q != '0)
		else $error("title phase with no bytes left");

	a_uid_left: assert property (@(posedge clk) disable iff (!arst_n)
		parse_phase_q == ntte_pkg::PH_UID |-> (bytes_left_q != '0 && bytes_left_q <= 16'd4))
		else $error("uid count out of range");

	a_pos_in_packet: assert property (@(posedge clk) disable iff (!arst_n)
		byte_position_q != '0 |-> byte_position_q < latched_length_q)
		else $error("byte position past packet end");

endmodule

[hdl/ntte_out_reg.sv]
// Result register that holds one item until the downstream side takes it.
module ntte_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  ntte_pkg::res_t load_res,
	input  logic           take,
	output logic           full,
	output ntte_pkg::res_t res
);

	logic           valid_q;
	ntte_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= load_res;
	end

	assign full = valid_q;
	assign res  = res_q;

endmodule

[hdl/notification_title_tlv_extractor_core.sv]
// Top level of the notification title extractor: input register, parser, result register.
//
// Takes a response packet one byte per item, with the packet length sampled on the first
// byte, and gives at most one result item per input byte: one status per packet (found,
// too short, bad command, malformed or absent), and after a found status the clipped
// title bytes as character items, the last one marked with title_end. An accepted byte
// sits in the input register, is parsed by the step logic and lands in the
// result register, so a result is always offered from a register and never straight from the parse.
// The block takes one byte every cycle as long as the result register drains; the input
// register holds a byte while a result waits, and in_ready drops only when both are
// occupied and the waiting result is not being taken.
// Write the three registers (expected command, title attribute, title limit) only while
// no packet is in flight; an index beyond the last register is ignored.
module notification_title_tlv_extractor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [15:0] packet_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [2:0]  status_code,
	output logic [15:0] title_length,
	output logic [7:0]  title_char,
	output logic        title_end
);

	ntte_pkg::cfg_t cfg_q;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic [15:0] length_s1;

	logic           advance, res_valid, out_full;
	ntte_pkg::res_t res_step, res_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_command <= 8'd0;
			cfg_q.title_attribute  <= 8'd1;
			cfg_q.title_limit      <= 16'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ntte_pkg::REG_EXPECTED_COMMAND: cfg_q.expected_command <= cfg_data[7:0];
				ntte_pkg::REG_TITLE_ATTRIBUTE:  cfg_q.title_attribute  <= cfg_data[7:0];
				ntte_pkg::REG_TITLE_LIMIT:      cfg_q.title_limit      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// advance the held byte once the result register can take what it may produce
	assign advance  = valid_s1 && (!out_full || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1   <= data_byte;
			length_s1 <= packet_length;
		end
	end

	ntte_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.step          (advance),
		.data_byte     (data_s1),
		.packet_length (length_s1),
		.res_valid     (res_valid),
		.res           (res_step)
	);

	ntte_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.load_res (res_step),
		.take     (out_ready),
		.full     (out_full),
		.res      (res_out)
	);

	assign out_valid    = out_full;
	assign result_kind  = res_out.result_kind;
	assign status_code  = res_out.status_code;
	assign title_length = res_out.title_length;
	assign title_char   = res_out.title_char;
	assign title_end    = res_out.title_end;

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> out_valid)
		else $error("parsed result not held in result register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !advance)
		else $error("byte advanced over a waiting result");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input register empty but not ready");

endmodule

[tb/sv/notification_title_tlv_extractor_core_tb.sv]
// Self-checking testbench for the notification title extractor: directed and random packets.
module notification_title_tlv_extractor_core_tb;

	// Index past the last register: the block must ignore writes to it
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// Predicts the result items of the extractor and checks the block against them.
	class title_scoreboard;
		ntte_pkg::cfg_t cfg;
		logic [15:0]    pos;
		logic [15:0]    plen;
		logic [2:0]     phase;
		logic [7:0]     rec_id;
		logic [15:0]    rec_len;
		logic [15:0]    left;
		ntte_pkg::res_t expq[$];
		int             errors;
		int             statuses;
		int             chars;

		function new();
			cfg      = '{expected_command: 8'h00, title_attribute: 8'h01, title_limit: 16'd255};
			pos      = '0;
			plen     = '0;
			phase    = ntte_pkg::PH_CMD;
			rec_id   = '0;
			rec_len  = '0;
			left     = '0;
			errors   = 0;
			statuses = 0;
			chars    = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] value);
			case (idx)
				ntte_pkg::REG_EXPECTED_COMMAND: cfg.expected_command = value[7:0];
				ntte_pkg::REG_TITLE_ATTRIBUTE:  cfg.title_attribute  = value[7:0];
				ntte_pkg::REG_TITLE_LIMIT:      cfg.title_limit      = value;
				default: ;
			endcase
		endfunction

		// Advance the parser by one accepted byte and queue the result it causes.
		function void note_byte(logic [7:0] b, logic [15:0] plen_in);
			int unsigned    p;
			int unsigned    rem;
			int unsigned    clip;
			bit             last;
			bit             got;
			ntte_pkg::res_t r;
			p = 32'(pos);
			if (p == 0) begin
				plen  = plen_in;
				phase = ntte_pkg::PH_CMD;
			end
			last = (p + 1 >= plen);
			rem  = last ? 0 : plen - p - 1;
			r    = '0;
			got  = 1'b0;
			case (phase)
				ntte_pkg::PH_CMD: begin
					if (plen < ntte_pkg::MIN_PACKET) begin
						r.status_code = ntte_pkg::ST_SHORT;
						got   = 1'b1;
						phase = ntte_pkg::PH_DONE;
					end else if (b != cfg.expected_command) begin
						r.status_code = ntte_pkg::ST_BADCMD;
						got   = 1'b1;
						phase = ntte_pkg::PH_DONE;
					end else begin
						phase = ntte_pkg::PH_UID;
						left  = ntte_pkg::UID_BYTES;
					end
				end
				ntte_pkg::PH_UID: begin
					left = left - 16'd1;
					if (left == 0) phase = ntte_pkg::PH_ID;
				end
				ntte_pkg::PH_ID: begin
					// fewer than a header's worth of bytes left: drop them
					if (rem + 1 >= ntte_pkg::HEADER_BYTES) begin
						rec_id = b;
						phase  = ntte_pkg::PH_LO;
					end
				end
				ntte_pkg::PH_LO: begin
					rec_len = {8'h00, b};
					phase   = ntte_pkg::PH_HI;
				end
				ntte_pkg::PH_HI: begin
					rec_len = {b, rec_len[7:0]};
					if (rec_len > rem) begin
						r.status_code = ntte_pkg::ST_MALFORMED;
						got   = 1'b1;
						phase = ntte_pkg::PH_DONE;
					end else if (rec_id == cfg.title_attribute) begin
						clip = (rec_len < cfg.title_limit) ? 32'(rec_len)
							: 32'(cfg.title_limit);
						r.status_code  = ntte_pkg::ST_FOUND;
						r.title_length = 16'(clip);
						got = 1'b1;
						if (clip == 0) begin
							phase = ntte_pkg::PH_DONE;
						end else begin
							phase = ntte_pkg::PH_TITLE;
							left  = 16'(clip);
						end
					end else if (rec_len == 0) begin
						phase = ntte_pkg::PH_ID;
					end else begin
						phase = ntte_pkg::PH_SKIP;
						left  = rec_len;
					end
				end
				ntte_pkg::PH_SKIP: begin
					left = left - 16'd1;
					if (left == 0) phase = ntte_pkg::PH_ID;
				end
				ntte_pkg::PH_TITLE: begin
					left = left - 16'd1;
					r.result_kind = ntte_pkg::KIND_CHAR;
					r.title_char  = b;
					r.title_end   = (left == 0);
					got = 1'b1;
					if (left == 0) phase = ntte_pkg::PH_DONE;
				end
				default: ;
			endcase
			if (last) begin
				if (!got && phase != ntte_pkg::PH_DONE) begin
					r.status_code = ntte_pkg::ST_ABSENT;
					got = 1'b1;
				end
				pos   = '0;
				phase = ntte_pkg::PH_CMD;
			end else begin
				pos = 16'(p + 1);
			end
			if (got) expq.push_back(r);
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(ntte_pkg::res_t got);
			ntte_pkg::res_t want;
			if (expq.size() == 0) begin
				$display("%0t: result with none expected: kind %0d code %0d length %0h char %02h end %0d",
					$time, got.result_kind, got.status_code, got.title_length, got.title_char,
					got.title_end);
				errors++;
				return;
			end
			want = expq.pop_front();
			compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
			compare_field("status_code", 16'(want.status_code), 16'(got.status_code));
			compare_field("title_length", want.title_length, got.title_length);
			compare_field("title_char", 16'(want.title_char), 16'(got.title_char));
			compare_field("title_end", 16'(want.title_end), 16'(got.title_end));
			if (want.result_kind == ntte_pkg::KIND_CHAR) chars++;
			else statuses++;
		endfunction

		function int pending();
			return expq.size();
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_index     = '0;
	logic [15:0] cfg_data      = '0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte     = '0;
	logic [15:0] packet_length = '0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic        result_kind;
	logic [2:0]  status_code;
	logic [15:0] title_length;
	logic [7:0]  title_char;
	logic        title_end;

	ntte_pkg::res_t seen;
	assign seen = {result_kind, status_code, title_length, title_char, title_end};

	notification_title_tlv_extractor_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.packet_length (packet_length),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.status_code   (status_code),
		.title_length  (title_length),
		.title_char    (title_char),
		.title_end     (title_end)
	);

	title_scoreboard sb;

	logic [7:0] pkt[$];      // bytes of the packet about to be sent
	int         bytes_sent = 0;
	int         packets    = 0;
	int         settings   = 1;
	logic       steady     = 1'b0;  // no idling on either side while set
	logic       stall_req  = 1'b0;  // toggle to start a long receiver hold-off
	logic       stall_ack  = 1'b0;
	int         stall_left = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: check every accepted result item, then pick ready for the next cycle.
	// A toggle of stall_req starts a long hold-off, counted here, that lets the block
	// fill up and push back on the sender.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(seen);
		if (stall_req != stall_ack) begin
			stall_ack  <= stall_req;
			stall_left <= 400;
			out_ready  <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 25);
		end
	end

	// Drop valid for a random number of cycles, about a quarter of the time.
	task automatic idle_gap();
		while (!steady && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Offer one byte and hold it until the block takes it.
	task automatic push_byte(input logic [7:0] b, input logic [15:0] plen);
		idle_gap();
		in_valid      <= 1'b1;
		data_byte     <= b;
		packet_length <= plen;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b, plen);
		bytes_sent++;
	endtask

	// Send the queued packet; only the first byte carries a meaningful length, the
	// others carry noise that the block must ignore.
	task automatic send_packet(input int unsigned plen);
		push_byte(pkt[0], 16'(plen));
		for (int i = 1; i < pkt.size(); i++) push_byte(pkt[i], 16'($urandom_range(65535)));
		packets++;
	endtask

	// Wait until every expected item is out and the pipeline has gone quiet.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, value);
	endtask

	// Build a random packet: mostly well-formed record walks with random content,
	// some with overlong records or short tails, and some pure noise.
	task automatic build_packet();
		int unsigned n;
		int unsigned avail;
		int unsigned dlen;
		int unsigned fill;
		int unsigned pick;
		logic [7:0]  id;
		pkt.delete();
		if ($urandom_range(99) < 20) begin
			n = $urandom_range(1, 12);
			pkt.push_back($urandom_range(1) ? sb.cfg.expected_command : 8'($urandom_range(255)));
			while (pkt.size() < n) pkt.push_back(8'($urandom_range(255)));
		end else begin
			n = ($urandom_range(9) == 0) ? $urandom_range(5, 200) : $urandom_range(5, 36);
			pkt.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255))
				: sb.cfg.expected_command);
			repeat (4) pkt.push_back(8'($urandom_range(255)));
			while (pkt.size() < n) begin
				avail = n - pkt.size();
				if (avail < 3) begin
					pkt.push_back(8'($urandom_range(255)));
				end else begin
					id   = ($urandom_range(99) < 35) ? sb.cfg.title_attribute
						: 8'($urandom_range(255));
					pick = $urandom_range(99);
					if (pick < 15) dlen = 0;
					else if (pick < 85) dlen = $urandom_range(0, avail - 3);
					else if (pick < 95) dlen = avail - 3 + $urandom_range(1, 4);
					else dlen = $urandom_range(0, 65535);
					pkt.push_back(id);
					pkt.push_back(8'(dlen));
					pkt.push_back(8'(dlen >> 8));
					fill = (dlen < n - pkt.size()) ? dlen : n - pkt.size();
					repeat (fill) pkt.push_back(8'($urandom_range(255)));
				end
			end
		end
	endtask

	// Load a register setting, stream random packets for the given number of bytes,
	// then drain so the next setting can be written safely.
	task automatic run_phase(input logic [7:0] cmd, input logic [7:0] attr,
			input logic [15:0] limit, input int budget);
		int start;
		write_reg(ntte_pkg::REG_EXPECTED_COMMAND, {8'h00, cmd});
		write_reg(ntte_pkg::REG_TITLE_ATTRIBUTE, {8'h00, attr});
		write_reg(ntte_pkg::REG_TITLE_LIMIT, limit);
		settings++;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			build_packet();
			send_packet(pkt.size());
		end
		drain();
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed packets under the reset register values.
		// zero length: latched as is and rejected as too short
		pkt = '{8'h00};
		send_packet(0);
		// below the minimum length, matching command
		pkt = '{8'h00, 8'h01, 8'h02, 8'h03};
		send_packet(4);
		// wrong command byte
		pkt = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
		send_packet(5);
		// UID only, no records: absent on the last byte
		pkt = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
		send_packet(5);
		// three-byte title followed by a byte to ignore
		pkt = '{8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h01, 8'h03, 8'h00,
			8'h61, 8'h62, 8'h63, 8'hEE};
		send_packet(12);
		// record data runs past the packet end
		pkt = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h02, 8'h05, 8'h00, 8'h55};
		send_packet(9);
		// empty foreign record, then a two-byte tail too short for a header
		pkt = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h07, 8'h00, 8'h00, 8'hAA, 8'hBB};
		send_packet(10);
		// title record of length zero
		pkt = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h01, 8'h00, 8'h00};
		send_packet(8);
		drain();

		// Extremes: all-ones command, attribute zero, every title clipped to nothing
		run_phase(8'hFF, 8'h00, 16'd0, 300);

		// Largest limit, plus one long packet whose title fills it to the last byte
		write_reg(REG_UNUSED, 16'($urandom_range(65535)));
		run_phase(8'($urandom_range(255)), 8'hFF, 16'hFFFF, 300);
		pkt.delete();
		pkt.push_back(sb.cfg.expected_command);
		repeat (4) pkt.push_back(8'($urandom_range(255)));
		pkt.push_back(sb.cfg.title_attribute);
		pkt.push_back(8'hF8);
		pkt.push_back(8'h00);
		while (pkt.size() < 256) pkt.push_back(8'($urandom_range(255)));
		send_packet(256);
		drain();

		// One-byte limit with no idling on either side
		steady <= 1'b1;
		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 16'd1, 300);
		steady <= 1'b0;

		// Small limit while the receiver holds off and the block backs up
		stall_req <= ~stall_req;
		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
			16'($urandom_range(2, 40)), 400);

		// Fully random setting, with one more hold-off
		stall_req <= ~stall_req;
		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
			16'($urandom_range(65535)), 400);

		repeat (10) @(posedge clk);
		$display("Sent %0d bytes in %0d packets under %0d register settings.",
			bytes_sent, packets, settings);
		$display("Checked %0d status items and %0d title characters, %0d mismatches.",
			sb.statuses, sb.chars, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Hard stop far beyond the slowest correct run
	initial begin
		#40000000;
		$display("Timed out with %0d items still expected.", sb.pending());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
hdl/ntte_pkg.sv
hdl/ntte_parser.sv
hdl/ntte_out_reg.sv
hdl/notification_title_tlv_extractor_core.sv
tb/sv/notification_title_tlv_extractor_core_tb.sv
